>>> hdl/arc_pkg.sv
// Shared types, constants and helper functions of the ASCII radix converter.
`default_nettype none

package arc_pkg;

    // ASCII codes used by the digit decoder and the character encoder.
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_UA    = 8'h41;
    localparam logic [7:0] CHAR_UF    = 8'h46;
    localparam logic [7:0] CHAR_LA    = 8'h61;
    localparam logic [7:0] CHAR_LF    = 8'h66;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;

    // Conversion modes.
    localparam logic [2:0] MODE_DEC_BIN  = 3'd0;
    localparam logic [2:0] MODE_DEC_HEX  = 3'd1;
    localparam logic [2:0] MODE_DEC_CHAR = 3'd2;
    localparam logic [2:0] MODE_HEX_BIN  = 3'd3;
    localparam logic [2:0] MODE_HEX_DEC  = 3'd4;
    localparam logic [2:0] MODE_BIN_DEC  = 3'd5;
    localparam logic [2:0] MODE_BIN_HEX  = 3'd6;
    localparam logic [2:0] MODE_UNDEF    = 3'd7;

    // Register indexes of the configuration port.
    localparam logic [1:0] REG_CONV_MODE    = 2'd0;
    localparam logic [1:0] REG_RESULT_LIMIT = 2'd1;

    // Status codes of a result item.
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BAD      = 2'd1;
    localparam logic [1:0] ST_TOO_LONG = 2'd2;

    // Radix classes of the digit decoder.
    localparam logic [1:0] RDX_DEC = 2'd0;
    localparam logic [1:0] RDX_HEX = 2'd1;
    localparam logic [1:0] RDX_BIN = 2'd2;

    localparam int DABBLE_STEPS = 32;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_PREP   = 6'b000010,
        S_DABBLE = 6'b000100,
        S_ALIGN  = 6'b001000,
        S_EMIT   = 6'b010000,
        S_SINGLE = 6'b100000
    } arc_state_t;

    typedef enum logic [1:0] {
        RT_NONE   = 2'd0,
        RT_SINGLE = 2'd1,
        RT_DABBLE = 2'd2,
        RT_ALIGN  = 2'd3
    } arc_route_t;

    typedef struct packed {
        logic accept;
        logic prep;
        logic dab_step;
        logic align_shift;
        logic align_done;
        logic emit;
        logic single;
        logic clear;
    } arc_cmd_t;

    typedef struct packed {
        arc_route_t route;
        logic       dab_last;
        logic       align_stop;
        logic       chk_err;
        logic       emit_last;
    } arc_stat_t;

    // Returns {valid, value} of a character under the given radix class.
    function automatic logic [4:0] digit_value(input logic [7:0] c, input logic [1:0] rdx);
        logic [3:0] v;
        logic       ok;
        v  = 4'd0;
        ok = 1'b0;
        if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
            v  = 4'(c - CHAR_ZERO);
            ok = 1'b1;
        end else if (c >= CHAR_UA && c <= CHAR_UF) begin
            v  = 4'(c - CHAR_UA) + 4'd10;
            ok = 1'b1;
        end else if (c >= CHAR_LA && c <= CHAR_LF) begin
            v  = 4'(c - CHAR_LA) + 4'd10;
            ok = 1'b1;
        end
        case (rdx)
            RDX_DEC: ok = ok && (v < 4'd10);
            RDX_BIN: ok = ok && (v < 4'd2);
            default: ok = ok;
        endcase
        return {ok, v};
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] v);
        return (v < 4'd10) ? (CHAR_ZERO + 8'(v)) : (CHAR_UA + 8'(v - 4'd10));
    endfunction

endpackage

`default_nettype wire

>>> hdl/arc_if.sv
// Valid/ready channel interfaces for characters in and result items out.
`default_nettype none

interface arc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_char;
    logic       char_present;
    logic       string_end;

    modport source (output valid, output in_char, output char_present, output string_end,
                    input ready);
    modport sink   (input valid, input in_char, input char_present, input string_end,
                    output ready);
endinterface

interface arc_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_char;
    logic       out_present;
    logic       out_last;
    logic [1:0] status;

    modport source (output valid, output out_char, output out_present, output out_last,
                    output status, input ready);
    modport sink   (input valid, input out_char, input out_present, input out_last,
                    input status, output ready);
endinterface

`default_nettype wire

>>> hdl/arc_datapath.sv
// Datapath: accumulator, BCD converter, alignment shifter and result register.
`default_nettype none

module arc_datapath #(
    parameter int MAX_RESULT_CHARS = 64,
    parameter int HEX_DIGITS_MAX   = 16
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cfg_we,
    input  wire logic [1:0]       cfg_index,
    input  wire logic [6:0]       cfg_data,
    input  wire logic [7:0]       in_char,
    input  wire logic             char_present,
    input  wire arc_pkg::arc_cmd_t  cmd,
    output arc_pkg::arc_stat_t      stat,
    output logic [7:0]            out_char,
    output logic                  out_present,
    output logic                  out_last,
    output logic [1:0]            status
);
    import arc_pkg::*;

    logic [2:0]  mode_reg;
    logic [6:0]  limit_reg;
    logic [63:0] accum_reg, accum_next;
    logic [6:0]  dc_reg, dc_next;
    logic        bad_reg, bad_next;
    logic        ovf_reg, ovf_next;
    logic [63:0] work_reg;
    logic [71:0] dab_reg;
    logic [5:0]  cnt_reg;
    logic [5:0]  target_reg;
    logic [6:0]  total_reg;
    logic [6:0]  len_reg;
    logic        neg_reg;
    logic        fixed_reg, nib_reg, bitemit_reg, hexchk_reg;
    logic [7:0]  sing_char_reg;
    logic        sing_pres_reg;
    logic [1:0]  sing_st_reg;
    logic [7:0]  out_char_reg;
    logic        out_present_reg, out_last_reg;
    logic [1:0]  status_reg;

    // Character decode and accumulation.
    logic [1:0]  rdx;
    logic [4:0]  dv;
    logic [67:0] dec_sum;

    always_comb begin
        if (mode_reg <= MODE_DEC_CHAR)     rdx = RDX_DEC;
        else if (mode_reg <= MODE_HEX_DEC) rdx = RDX_HEX;
        else                               rdx = RDX_BIN;
        dv      = digit_value(in_char, rdx);
        dec_sum = {1'b0, accum_reg, 3'b000} + {3'b000, accum_reg, 1'b0} + 68'(dv[3:0]);
    end

    always_comb begin
        accum_next = accum_reg;
        dc_next    = dc_reg;
        bad_next   = bad_reg;
        ovf_next   = ovf_reg;
        if (cmd.clear) begin
            accum_next = '0;
            dc_next    = '0;
            bad_next   = 1'b0;
            ovf_next   = 1'b0;
        end else if (cmd.accept && char_present && mode_reg != MODE_UNDEF) begin
            if (!dv[4]) begin
                bad_next = 1'b1;
            end else begin
                case (rdx)
                    RDX_DEC:
                        if (ovf_reg || dec_sum[67:64] != 4'd0) ovf_next = 1'b1;
                        else accum_next = dec_sum[63:0];
                    RDX_HEX: accum_next = {accum_reg[59:0], dv[3:0]};
                    default: accum_next = {accum_reg[62:0], dv[0]};
                endcase
                if (dc_reg != 7'd127) dc_next = dc_reg + 7'd1;
            end
        end
    end

    // End-of-string decisions, evaluated on the settled string state.
    logic [6:0]  cap;
    logic [63:0] v_unsigned, v_signed;
    logic [8:0]  bits4;
    logic [5:0]  hexk;
    logic [31:0] mag;

    always_comb begin
        cap        = (limit_reg == 7'd0) ? 7'd0 : limit_reg - 7'd1;
        if (cap > 7'(MAX_RESULT_CHARS)) cap = 7'(MAX_RESULT_CHARS);
        v_unsigned = ovf_reg ? '1 : accum_reg;
        v_signed   = (ovf_reg || accum_reg[63]) ? {1'b0, {63{1'b1}}} : accum_reg;
        bits4      = {dc_reg, 2'b00};
        hexk       = 6'((8'(dc_reg) + 8'd3) >> 2);
        mag        = accum_reg[31] ? (32'd0 - accum_reg[31:0]) : accum_reg[31:0];
    end

    logic       p_route_single;
    arc_route_t p_route;
    logic [7:0] p_char;
    logic       p_pres;
    logic [1:0] p_st;

    always_comb begin
        p_char = 8'd0;
        p_pres = 1'b0;
        p_st   = ST_OK;
        p_route = RT_ALIGN;
        if (mode_reg == MODE_UNDEF) begin
            p_route = RT_NONE;
        end else if (bad_reg || (mode_reg == MODE_DEC_BIN && dc_reg == 7'd0)) begin
            p_route = RT_SINGLE;
            p_st    = ST_BAD;
        end else begin
            case (mode_reg)
                MODE_DEC_CHAR: begin
                    p_route = RT_SINGLE;
                    if (v_signed > 64'd255 || cap == 7'd0) begin
                        p_st = ST_TOO_LONG;
                    end else begin
                        p_char = v_signed[7:0];
                        p_pres = 1'b1;
                    end
                end
                MODE_HEX_BIN: begin
                    if (dc_reg == 7'd0) begin
                        p_route = RT_SINGLE;
                    end else if (dc_reg > 7'(HEX_DIGITS_MAX) || bits4 > 9'(cap)) begin
                        p_route = RT_SINGLE;
                        p_st    = ST_TOO_LONG;
                    end
                end
                MODE_BIN_HEX: begin
                    if (hexk == 6'd0) begin
                        p_route = RT_SINGLE;
                    end else if (hexk > 6'(HEX_DIGITS_MAX) || 7'(hexk) > cap) begin
                        p_route = RT_SINGLE;
                        p_st    = ST_TOO_LONG;
                    end
                end
                MODE_HEX_DEC, MODE_BIN_DEC: p_route = RT_DABBLE;
                default: p_route = RT_ALIGN;
            endcase
        end
    end
    assign p_route_single = (p_route == RT_SINGLE);

    // Double-dabble step: add three to every BCD digit of five or more, then shift.
    logic [39:0] bcd_adj;
    logic [71:0] dab_nx;

    always_comb begin
        for (int i = 0; i < 10; i++) begin
            bcd_adj[4*i +: 4] = (dab_reg[32 + 4*i +: 4] >= 4'd5) ?
                                dab_reg[32 + 4*i +: 4] + 4'd3 : dab_reg[32 + 4*i +: 4];
        end
        dab_nx = {bcd_adj[38:0], dab_reg[31:0], 1'b0};
    end

    // Alignment and length check.
    logic       top_nz;
    logic [6:0] len_calc;
    logic [7:0] chars;

    always_comb begin
        top_nz   = nib_reg ? (work_reg[63:60] != 4'd0) : work_reg[63];
        len_calc = fixed_reg ? total_reg : total_reg - 7'(cnt_reg);
        chars    = 8'(len_calc) + 8'(neg_reg);
    end

    always_comb begin
        stat.route      = p_route;
        stat.dab_last   = (cnt_reg == 6'(DABBLE_STEPS - 1));
        stat.align_stop = fixed_reg ? (cnt_reg == target_reg)
                                    : (top_nz || cnt_reg == target_reg);
        stat.chk_err    = (chars > 8'(cap)) ||
                          (hexchk_reg && len_calc > 7'(HEX_DIGITS_MAX));
        stat.emit_last  = !neg_reg && len_reg == 7'd1;
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            mode_reg  <= MODE_DEC_BIN;
            limit_reg <= 7'd65;
            accum_reg <= '0;
            dc_reg    <= '0;
            bad_reg   <= 1'b0;
            ovf_reg   <= 1'b0;
        end else begin
            if (cfg_we && cfg_index == REG_CONV_MODE)    mode_reg  <= cfg_data[2:0];
            if (cfg_we && cfg_index == REG_RESULT_LIMIT) limit_reg <= cfg_data;
            accum_reg <= accum_next;
            dc_reg    <= dc_next;
            bad_reg   <= bad_next;
            ovf_reg   <= ovf_next;
        end
    end

    always_ff @(posedge clk) begin
        if (cmd.prep) begin
            cnt_reg       <= '0;
            neg_reg       <= 1'b0;
            hexchk_reg    <= 1'b0;
            sing_char_reg <= p_char;
            sing_pres_reg <= p_pres;
            sing_st_reg   <= p_st;
            dab_reg       <= {40'd0, mag};
            case (mode_reg)
                MODE_DEC_BIN: begin
                    work_reg    <= v_unsigned;
                    fixed_reg   <= 1'b0;
                    nib_reg     <= 1'b0;
                    bitemit_reg <= 1'b1;
                    target_reg  <= 6'd63;
                    total_reg   <= 7'd64;
                end
                MODE_DEC_HEX: begin
                    work_reg    <= v_signed;
                    fixed_reg   <= 1'b0;
                    nib_reg     <= 1'b1;
                    bitemit_reg <= 1'b0;
                    hexchk_reg  <= 1'b1;
                    target_reg  <= 6'd15;
                    total_reg   <= 7'd16;
                end
                MODE_HEX_BIN: begin
                    work_reg    <= accum_reg;
                    fixed_reg   <= 1'b1;
                    nib_reg     <= 1'b1;
                    bitemit_reg <= 1'b1;
                    target_reg  <= 6'd16 - dc_reg[5:0];
                    total_reg   <= bits4[6:0];
                end
                MODE_BIN_HEX: begin
                    work_reg    <= accum_reg;
                    fixed_reg   <= 1'b1;
                    nib_reg     <= 1'b1;
                    bitemit_reg <= 1'b0;
                    target_reg  <= 6'd16 - hexk;
                    total_reg   <= 7'(hexk);
                end
                default: begin
                    work_reg    <= accum_reg;
                    fixed_reg   <= 1'b0;
                    nib_reg     <= 1'b1;
                    bitemit_reg <= 1'b0;
                    target_reg  <= 6'd9;
                    total_reg   <= 7'd10;
                    neg_reg     <= accum_reg[31];
                end
            endcase
        end else if (cmd.dab_step) begin
            dab_reg <= dab_nx;
            if (stat.dab_last) begin
                cnt_reg  <= '0;
                work_reg <= {dab_nx[71:32], 24'd0};
            end else begin
                cnt_reg <= cnt_reg + 6'd1;
            end
        end else if (cmd.align_shift) begin
            work_reg <= nib_reg ? {work_reg[59:0], 4'd0} : {work_reg[62:0], 1'b0};
            cnt_reg  <= cnt_reg + 6'd1;
        end else if (cmd.align_done) begin
            len_reg     <= len_calc;
            sing_char_reg <= 8'd0;
            sing_pres_reg <= 1'b0;
            sing_st_reg   <= ST_TOO_LONG;
        end else if (cmd.emit) begin
            if (neg_reg) begin
                neg_reg <= 1'b0;
            end else begin
                work_reg <= bitemit_reg ? {work_reg[62:0], 1'b0} : {work_reg[59:0], 4'd0};
                len_reg  <= len_reg - 7'd1;
            end
        end

        if (cmd.emit) begin
            out_present_reg <= 1'b1;
            out_last_reg    <= stat.emit_last;
            status_reg      <= ST_OK;
            if (neg_reg)          out_char_reg <= CHAR_MINUS;
            else if (bitemit_reg) out_char_reg <= CHAR_ZERO + 8'(work_reg[63]);
            else                  out_char_reg <= hex_char(work_reg[63:60]);
        end else if (cmd.single) begin
            out_char_reg    <= sing_char_reg;
            out_present_reg <= sing_pres_reg;
            out_last_reg    <= 1'b1;
            status_reg      <= sing_st_reg;
        end
    end

    assign out_char    = out_char_reg;
    assign out_present = out_present_reg;
    assign out_last    = out_last_reg;
    assign status      = status_reg;

`ifndef SYNTHESIS
    a_single_route_keeps_status: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.prep && p_route_single && p_pres |-> p_st == ST_OK)
        else $error("character result prepared with an error status");
    a_emit_has_digits: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit && !neg_reg |-> len_reg != 7'd0)
        else $error("digit emitted with no digits left");
    a_count_not_cleared_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.accept && !cmd.clear && dc_reg != 7'd127 && char_present && dv[4]
        && mode_reg != MODE_UNDEF |=> dc_reg == $past(dc_reg) + 7'd1)
        else $error("digit counter did not advance on a valid digit");
`endif

endmodule

`default_nettype wire

>>> hdl/arc_controller.sv
// Controller state machine sequencing accumulation, conversion and emission.
`default_nettype none

module arc_controller (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    input  wire logic              string_end,
    output logic                   in_ready,
    output logic                   out_valid,
    input  wire logic              out_ready,
    input  wire arc_pkg::arc_stat_t stat,
    output arc_pkg::arc_cmd_t       cmd
);
    import arc_pkg::*;

    arc_state_t state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       out_free;

    assign out_free = !out_valid_reg || out_ready;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                in_ready   = 1'b1;
                cmd.accept = in_valid;
                if (in_valid && string_end) state_next = S_PREP;
            end
            S_PREP: begin
                cmd.prep = 1'b1;
                unique case (stat.route)
                    RT_NONE: begin
                        cmd.clear  = 1'b1;
                        state_next = S_IDLE;
                    end
                    RT_SINGLE: state_next = S_SINGLE;
                    RT_DABBLE: state_next = S_DABBLE;
                    default:   state_next = S_ALIGN;
                endcase
            end
            S_DABBLE: begin
                cmd.dab_step = 1'b1;
                if (stat.dab_last) state_next = S_ALIGN;
            end
            S_ALIGN: begin
                if (stat.align_stop) begin
                    cmd.align_done = 1'b1;
                    state_next     = stat.chk_err ? S_SINGLE : S_EMIT;
                end else begin
                    cmd.align_shift = 1'b1;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    cmd.emit = 1'b1;
                    if (stat.emit_last) begin
                        cmd.clear  = 1'b1;
                        state_next = S_IDLE;
                    end
                end
            end
            S_SINGLE: begin
                if (out_free) begin
                    cmd.single = 1'b1;
                    cmd.clear  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (out_ready) out_valid_next = 1'b0;
        if (cmd.emit || cmd.single) out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

`ifndef SYNTHESIS
    a_end_starts_prep: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && string_end |=> state_reg == S_PREP)
        else $error("string end did not start result preparation");
    a_load_only_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit || cmd.single |-> out_free)
        else $error("result register overwritten while still held");
    a_no_accept_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> state_reg == S_IDLE && !cmd.emit && !cmd.single)
        else $error("input taken while a string is being converted");
`endif

endmodule

`default_nettype wire

>>> hdl/ascii_radix_converter_unit.sv
// Top level of the ASCII radix converter: controller plus datapath.
//
// Usage. Characters of one number string arrive on the chr channel, one transaction
// each; string_end marks the last one (its character, if present, is taken first).
// The conv_mode (index 0) and result_limit (index 1) registers are written through
// cfg_we/cfg_index/cfg_data while no string is in flight; other indexes are ignored.
// While idle the block takes each character transaction at once, so characters
// may follow back to back. At string end the block stops taking input while it
// converts: it prepares, runs the BCD conversion for signed decimal output, then
// makes the alignment shifts (one digit each) and the length check, then gives one
// result transaction per cycle on res while the receiver is ready, most significant
// character first, out_last on the final one. Errors and empty results give a
// single transaction instead.
// The result register frees the input side as soon as the last result is loaded,
// so the next string may begin while that transaction still waits. When the
// receiver stalls, emission simply pauses; nothing is lost. Reset clears the
// string state and sets conv_mode to 0 and result_limit to 65.
`default_nettype none

module ascii_radix_converter_unit #(
    parameter int MAX_RESULT_CHARS = 64,
    parameter int HEX_DIGITS_MAX   = 16
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_we,
    input  wire logic [1:0] cfg_index,
    input  wire logic [6:0] cfg_data,
    arc_in_if.sink          chr,
    arc_out_if.source       res
);
    import arc_pkg::*;

    // Command and status bundles between the sequencer and the datapath.
    arc_cmd_t  cmd;
    arc_stat_t stat;

    arc_controller u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (chr.valid),
        .string_end (chr.string_end),
        .in_ready   (chr.ready),
        .out_valid  (res.valid),
        .out_ready  (res.ready),
        .stat       (stat),
        .cmd        (cmd)
    );

    arc_datapath #(
        .MAX_RESULT_CHARS (MAX_RESULT_CHARS),
        .HEX_DIGITS_MAX   (HEX_DIGITS_MAX)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_char      (chr.in_char),
        .char_present (chr.char_present),
        .cmd          (cmd),
        .stat         (stat),
        .out_char     (res.out_char),
        .out_present  (res.out_present),
        .out_last     (res.out_last),
        .status       (res.status)
    );

endmodule

`default_nettype wire

>>> sim/ascii_radix_converter_unit_test.sv
// Self-checking testbench of the ASCII radix converter, predictor included.
`timescale 1ns / 100ps

module ascii_radix_converter_unit_test;
    import arc_pkg::*;

    // One character transaction as the sender presents it.
    typedef struct {
        logic [7:0] ch;
        logic       pres;
        logic       fin;
    } char_txn_t;

    // One result transaction as the receiver should see it.
    typedef struct {
        logic [7:0] ch;
        logic       pres;
        logic       last;
        logic [1:0] st;
    } result_txn_t;

    localparam int CAP_MAX   = 64;
    localparam int HEX_MAX   = 16;
    localparam int DRAIN     = 200;
    localparam int CYCLE_CAP = 2000000;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       cfg_we = 1'b0;
    logic [1:0] cfg_index = REG_CONV_MODE;
    logic [6:0] cfg_data = '0;

    arc_in_if  chr ();
    arc_out_if res ();

    ascii_radix_converter_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .chr       (chr.sink),
        .res       (res.source)
    );

    always #2 clk = ~clk;

    char_txn_t   pending_chars[$];
    result_txn_t awaited_results[$];
    bit          failed = 1'b0;
    bit          hold_sender = 1'b0;
    int unsigned cycles = 0;

    // Shadow of the configuration registers and of the string state.
    logic [2:0]  mode_reg = MODE_DEC_BIN;
    logic [6:0]  limit_reg = 7'd65;
    logic [63:0] value_acc = '0;
    int unsigned digits_seen = 0;
    bit          saw_bad = 1'b0;
    bit          saw_ovf = 1'b0;

    // Digit value of a character under a radix, or -1 when it is not a digit of it.
    function automatic int digit_of(input logic [7:0] c, input int radix);
        int v;
        if (c >= CHAR_ZERO && c <= CHAR_NINE) v = c - CHAR_ZERO;
        else if (c >= CHAR_UA && c <= CHAR_UF) v = c - CHAR_UA + 10;
        else if (c >= CHAR_LA && c <= CHAR_LF) v = c - CHAR_LA + 10;
        else v = -1;
        return (v >= 0 && v < radix) ? v : -1;
    endfunction

    function automatic logic [7:0] nibble_glyph(input logic [3:0] v);
        return (v < 10) ? CHAR_ZERO + 8'(v) : CHAR_UA + 8'(v - 10);
    endfunction

    function automatic void push_single(input logic [1:0] st);
        result_txn_t r;
        r.ch = 8'h00;
        r.pres = 1'b0;
        r.last = 1'b1;
        r.st = st;
        awaited_results.push_back(r);
    endfunction

    // Forms the expected result transactions of a finished string.
    function automatic void close_string();
        logic [7:0]  text[$];
        logic [63:0] v;
        logic [31:0] lo, mag;
        logic [7:0]  rev[$];
        logic [1:0]  st;
        int          cap, k;
        result_txn_t r;
        st = ST_OK;
        cap = (limit_reg < 1) ? 0 : limit_reg - 1;
        if (cap > CAP_MAX) cap = CAP_MAX;
        if (mode_reg > MODE_BIN_HEX) return;
        if (saw_bad || (mode_reg == MODE_DEC_BIN && digits_seen == 0)) begin
            push_single(ST_BAD);
            return;
        end
        case (mode_reg)
            MODE_DEC_BIN:
            begin
                v = saw_ovf ? '1 : value_acc;
                if (v == 0) text.push_back(CHAR_ZERO);
                else
                begin
                    k = 64;
                    while (!v[k-1]) k--;
                    if (k > cap) st = ST_TOO_LONG;
                    else for (int i = k - 1; i >= 0; i--) text.push_back(CHAR_ZERO + v[i]);
                end
            end
            MODE_DEC_HEX, MODE_DEC_CHAR:
            begin
                v = (saw_ovf || value_acc[63]) ? 64'h7FFF_FFFF_FFFF_FFFF : value_acc;
                if (mode_reg == MODE_DEC_CHAR)
                begin
                    if (v > 255) st = ST_TOO_LONG;
                    else text.push_back(v[7:0]);
                end
                else
                begin
                    k = 1;
                    while (k < 16 && (v >> (4 * k)) != 0) k++;
                    for (int i = k - 1; i >= 0; i--) text.push_back(nibble_glyph(v[4*i +: 4]));
                end
            end
            MODE_HEX_BIN:
            begin
                if (digits_seen > HEX_MAX || 4 * digits_seen > cap) st = ST_TOO_LONG;
                else for (int i = 4 * digits_seen - 1; i >= 0; i--)
                    text.push_back(CHAR_ZERO + value_acc[i]);
            end
            MODE_HEX_DEC, MODE_BIN_DEC:
            begin
                lo = value_acc[31:0];
                mag = lo[31] ? -lo : lo;
                do
                begin
                    rev.push_front(CHAR_ZERO + 8'(mag % 10));
                    mag = mag / 10;
                end while (mag != 0);
                if (lo[31]) text.push_back(CHAR_MINUS);
                foreach (rev[i]) text.push_back(rev[i]);
            end
            default:
            begin
                k = (digits_seen + 3) / 4;
                if (k > HEX_MAX || k > cap) st = ST_TOO_LONG;
                else for (int i = k - 1; i >= 0; i--)
                    text.push_back(nibble_glyph(value_acc[4*i +: 4]));
            end
        endcase
        if (st == ST_OK && text.size() > cap) st = ST_TOO_LONG;
        if (st != ST_OK) push_single(st);
        else if (text.size() == 0) push_single(ST_OK);
        else foreach (text[i])
        begin
            r.ch = text[i];
            r.pres = 1'b1;
            r.last = (i == text.size() - 1);
            r.st = ST_OK;
            awaited_results.push_back(r);
        end
    endfunction

    // Folds one accepted character transaction into the shadow state.
    function automatic void absorb_char(input char_txn_t t);
        int radix, d;
        if (t.pres && mode_reg <= MODE_BIN_HEX)
        begin
            radix = (mode_reg <= MODE_DEC_CHAR) ? 10 : (mode_reg <= MODE_HEX_DEC) ? 16 : 2;
            d = digit_of(t.ch, radix);
            if (d < 0) saw_bad = 1'b1;
            else
            begin
                if (radix == 10)
                begin
                    if (saw_ovf || value_acc > (64'hFFFF_FFFF_FFFF_FFFF - 64'(d)) / 10)
                        saw_ovf = 1'b1;
                    else value_acc = value_acc * 10 + 64'(d);
                end
                else if (radix == 16) value_acc = {value_acc[59:0], 4'(d)};
                else value_acc = {value_acc[62:0], 1'(d)};
                if (digits_seen < 127) digits_seen++;
            end
        end
        if (t.fin)
        begin
            close_string();
            value_acc = '0;
            digits_seen = 0;
            saw_bad = 1'b0;
            saw_ovf = 1'b0;
        end
    endfunction

    // Driver: sends pending characters in bursts separated by random gaps. The
    // prediction is made at the edge where a transaction is accepted.
    int burst_left = 4;
    int gap_left = 0;
    always @(posedge clk or negedge rst_n)
    begin
        char_txn_t t;
        if (!rst_n)
        begin
            chr.valid <= 1'b0;
            chr.in_char <= 8'h00;
            chr.char_present <= 1'b0;
            chr.string_end <= 1'b0;
        end
        else
        begin
            if (chr.valid && chr.ready)
            begin
                t.ch = chr.in_char;
                t.pres = chr.char_present;
                t.fin = chr.string_end;
                absorb_char(t);
            end
            if (!chr.valid || chr.ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    chr.valid <= 1'b0;
                end
                else if (pending_chars.size() != 0 && !hold_sender)
                begin
                    t = pending_chars.pop_front();
                    chr.in_char <= t.ch;
                    chr.char_present <= t.pres;
                    chr.string_end <= t.fin;
                    chr.valid <= 1'b1;
                    if (--burst_left <= 0)
                    begin
                        burst_left = $urandom_range(40, 1);
                        gap_left = ($urandom_range(3) == 0) ? 0 : $urandom_range(6);
                    end
                end
                else chr.valid <= 1'b0;
            end
        end
    end

    // Receiver: the stall pattern is drawn anew during the run, at random among
    // always ready, light stalls and heavy stalls.
    int stall_style = 0;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) res.ready <= 1'b0;
        else
        begin
            if (cycles % 300 == 0) stall_style = $urandom_range(2);
            case (stall_style)
                0: res.ready <= 1'b1;
                1: res.ready <= ($urandom_range(3) != 0);
                default: res.ready <= ($urandom_range(4) == 0);
            endcase
        end
    end

    // Monitor: every accepted result is checked against the oldest expectation.
    always @(posedge clk)
    begin
        result_txn_t e;
        if (rst_n && res.valid && res.ready)
        begin
            if (awaited_results.size() == 0)
            begin
                $error("unexpected result transaction, out_char %h", res.out_char);
                failed = 1'b1;
            end
            else
            begin
                e = awaited_results.pop_front();
                if (res.out_char !== e.ch)
                begin
                    $error("out_char expected %h actual %h", e.ch, res.out_char);
                    failed = 1'b1;
                end
                if (res.out_present !== e.pres)
                begin
                    $error("out_present expected %b actual %b", e.pres, res.out_present);
                    failed = 1'b1;
                end
                if (res.out_last !== e.last)
                begin
                    $error("out_last expected %b actual %b", e.last, res.out_last);
                    failed = 1'b1;
                end
                if (res.status !== e.st)
                begin
                    $error("status expected %0d actual %0d", e.st, res.status);
                    failed = 1'b1;
                end
            end
        end
    end

    // Watchdog against a hung handshake.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_CAP)
        begin
            $display("ascii_radix_converter_unit_test: FAIL");
            $finish;
        end
    end

    task automatic push_char(input logic [7:0] c, input bit fin);
        char_txn_t t;
        t.ch = c;
        t.pres = 1'b1;
        t.fin = fin;
        pending_chars.push_back(t);
    endtask

    task automatic push_empty_end();
        char_txn_t t;
        t.ch = $urandom_range(255);
        t.pres = 1'b0;
        t.fin = 1'b1;
        pending_chars.push_back(t);
    endtask

    // A whole string; when end_on_char is set the last character carries the end.
    task automatic push_string(input string s, input bit end_on_char);
        for (int i = 0; i < s.len(); i++)
            push_char(s[i], end_on_char && i == s.len() - 1);
        if (!end_on_char || s.len() == 0) push_empty_end();
    endtask

    // Waits until all characters are taken and all results have arrived; the
    // extra cycles cover strings that give no result at all.
    task automatic wait_quiet();
        while (pending_chars.size() != 0 || chr.valid || awaited_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [6:0] val);
        wait_quiet();
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_CONV_MODE) mode_reg = val[2:0];
        else if (idx == REG_RESULT_LIMIT) limit_reg = val;
    endtask

    // A random string for the given mode: mostly well formed digits, sometimes
    // with stray characters, empty ends or idle transactions mixed in.
    task automatic push_random_string(input logic [2:0] mode);
        int  len, radix, pick;
        bit  noisy;
        char_txn_t t;
        radix = (mode <= MODE_DEC_CHAR) ? 10 : (mode <= MODE_HEX_DEC) ? 16 : 2;
        pick = $urandom_range(9);
        if (pick < 6) len = $urandom_range(radix == 2 ? 20 : 8);
        else if (pick < 9) len = $urandom_range(radix == 2 ? 70 : 22);
        else len = 0;
        noisy = ($urandom_range(7) == 0);
        for (int i = 0; i < len; i++)
        begin
            if (noisy && $urandom_range(5) == 0) t.ch = $urandom_range(255);
            else
            begin
                pick = $urandom_range(radix - 1);
                if (pick < 10) t.ch = CHAR_ZERO + 8'(pick);
                else t.ch = ($urandom_range(1) ? CHAR_UA : CHAR_LA) + 8'(pick - 10);
            end
            if ($urandom_range(15) == 0)
            begin
                char_txn_t idle;
                idle.ch = $urandom_range(255);
                idle.pres = 1'b0;
                idle.fin = 1'b0;
                pending_chars.push_back(idle);
            end
            t.pres = 1'b1;
            t.fin = (i == len - 1) && $urandom_range(1);
            pending_chars.push_back(t);
            if (t.fin) return;
        end
        push_empty_end();
    endtask

    initial
    begin
        int items_goal;
        logic [2:0] m;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: extremes, every mode, empty strings and errors.
        push_string("18446744073709551615", 1'b1);
        push_string("99999999999999999999", 1'b0);
        push_string("", 1'b0);
        push_string("-5", 1'b1);
        write_reg(REG_RESULT_LIMIT, 7'd2);
        push_string("1", 1'b1);
        push_string("2", 1'b1);
        write_reg(REG_RESULT_LIMIT, 7'd65);
        write_reg(REG_CONV_MODE, MODE_DEC_CHAR);
        push_string("255", 1'b1);
        push_string("256", 1'b0);
        push_string("", 1'b0);
        write_reg(REG_CONV_MODE, MODE_HEX_BIN);
        push_string("fFfFfFfFfFfFfFfF", 1'b1);
        push_string("10000000000000000", 1'b1);
        push_string("", 1'b0);
        write_reg(REG_CONV_MODE, MODE_HEX_DEC);
        push_string("80000000", 1'b1);
        push_string("FFFFFFFF", 1'b1);
        push_string("g", 1'b1);
        write_reg(REG_CONV_MODE, MODE_BIN_HEX);
        push_string("", 1'b0);
        push_string("1", 1'b1);
        // Mode change part way through a string.
        push_string("101", 1'b0);
        pending_chars.pop_back();
        write_reg(REG_CONV_MODE, MODE_DEC_HEX);
        push_string("99", 1'b0);
        write_reg(REG_CONV_MODE, MODE_UNDEF);
        push_string("12", 1'b1);
        // Writes to unused indexes must change nothing.
        write_reg(2'd2, 7'h7F);
        write_reg(2'd3, 7'h00);
        write_reg(REG_CONV_MODE, MODE_BIN_DEC);
        push_string("10000000000000000000000000000000", 1'b1);

        // Random part in phases, each with its own configuration.
        items_goal = 300;
        while (items_goal > 0)
        begin
            m = ($urandom_range(12) == 0) ? MODE_UNDEF : 3'($urandom_range(6));
            write_reg(REG_CONV_MODE, m);
            case ($urandom_range(3))
                0: write_reg(REG_RESULT_LIMIT, 7'd2);
                1: write_reg(REG_RESULT_LIMIT, 7'd65);
                default: write_reg(REG_RESULT_LIMIT, 7'($urandom_range(65, 2)));
            endcase
            for (int s = 0; s < 6; s++)
            begin
                int before_size;
                before_size = pending_chars.size();
                push_random_string(m);
                items_goal -= pending_chars.size() - before_size;
                if (s == 3 && $urandom_range(2) == 0)
                begin
                    // Let the block drain completely before sending on.
                    hold_sender = 1'b1;
                    while (chr.valid || awaited_results.size() != 0) @(posedge clk);
                    hold_sender = 1'b0;
                end
            end
        end

        wait_quiet();
        if (!failed) $display("ascii_radix_converter_unit_test: PASS");
        else $display("ascii_radix_converter_unit_test: FAIL");
        $finish;
    end

endmodule

>>> ascii_radix_converter_unit.f
hdl/arc_pkg.sv
hdl/arc_if.sv
hdl/arc_datapath.sv
hdl/arc_controller.sv
hdl/ascii_radix_converter_unit.sv
sim/ascii_radix_converter_unit_test.sv
